FILE: design/ucp_pkg.sv
// ----------------------------------------------------------------------------
// ucp_pkg
// Shared types, codes and helpers of the command line parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ucp_pkg;

  localparam int LINE_CAPACITY = 32;
  localparam int POS_W         = $clog2(LINE_CAPACITY);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_CAPACITY - 1);

  localparam int SUF_W = 5;
  localparam logic [SUF_W-1:0] SUF_MAX = 5'd31;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // register indexes
  localparam logic REG_INTERVAL_MIN = 1'b0;
  localparam logic REG_INTERVAL_MAX = 1'b1;

  localparam logic [7:0] INTERVAL_MIN_RST = 8'd2;
  localparam logic [7:0] INTERVAL_MAX_RST = 8'd60;

  // request modes
  localparam logic [1:0] MODE_BYTE     = 2'd0;
  localparam logic [1:0] MODE_OVERFLOW = 2'd1;
  localparam logic [1:0] MODE_FRAMING  = 2'd2;

  // status codes
  localparam logic [3:0] ST_CLOCK_SET    = 4'd0;
  localparam logic [3:0] ST_SET_INTERVAL = 4'd1;
  localparam logic [3:0] ST_TIME_FMT     = 4'd2;
  localparam logic [3:0] ST_INTERVAL_FMT = 4'd3;
  localparam logic [3:0] ST_RANGE        = 4'd4;
  localparam logic [3:0] ST_UNKNOWN      = 4'd5;
  localparam logic [3:0] ST_OVERFLOW     = 4'd6;
  localparam logic [3:0] ST_FRAMING      = 4'd7;
  localparam logic [3:0] ST_TOO_LONG     = 4'd8;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_EQ    = 8'h3D;
  localparam logic [7:0] CHAR_I     = 8'h49;
  localparam logic [7:0] CHAR_M     = 8'h4D;

  localparam logic [11:0] HOUR_MAX  = 12'd23;
  localparam logic [11:0] MINSEC_MAX = 12'd59;
  localparam logic [11:0] BYTE_MAX  = 12'd255;

  typedef enum logic [2:0] {
    KIND_COMMON      = 3'd0,
    KIND_TIME_PREFIX = 3'd1,
    KIND_TM_PREFIX   = 3'd2,
    KIND_TIME_BODY   = 3'd3,
    KIND_TM_BODY     = 3'd4,
    KIND_UNKNOWN     = 3'd5
  } line_kind_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
  } ucp_in_t;

  typedef struct packed {
    logic [3:0] status;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [7:0] interval;
  } ucp_out_t;

  typedef struct packed {
    logic [7:0] interval_min;
    logic [7:0] interval_max;
  } ucp_cfg_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // characters of the time command prefix
  function automatic logic [7:0] time_char(input logic [POS_W-1:0] p);
    logic [7:0] c;
    case (p)
      POS_W'(0): c = 8'h53;
      POS_W'(1): c = 8'h45;
      POS_W'(2): c = 8'h54;
      POS_W'(3): c = 8'h5F;
      POS_W'(4): c = 8'h54;
      POS_W'(5): c = 8'h49;
      POS_W'(6): c = 8'h4D;
      POS_W'(7): c = 8'h45;
      POS_W'(8): c = 8'h3D;
      default:   c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: design/ucp_parser.sv
// ----------------------------------------------------------------------------
// ucp_parser
// Per-byte line state and status decision, one request per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucp_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  ucp_pkg::ucp_in_t in_item,
  input  ucp_pkg::ucp_cfg_t cfg,
  output logic             res_valid,
  output ucp_pkg::ucp_out_t res_data
);
  import ucp_pkg::*;

  line_kind_t        kind_r, kind_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              ended_r, ended_nxt;
  logic              fv_r, fv_nxt;
  logic [7:0]        acc_r, acc_nxt;
  logic [4:0]        hour_r, hour_nxt;
  logic [5:0]        min_r, min_nxt;
  logic [SUF_W-1:0]  suf_r, suf_nxt;

  logic        is_byte;
  logic        eol;
  logic        line_end;
  logic        room;
  logic        advance;
  logic        too_long;
  logic        clr;
  logic        parse_en;
  logic [7:0]  c;
  logic [3:0]  digit;
  logic [11:0] v;

  assign c        = in_item.rx_byte;
  assign digit    = c[3:0];
  assign v        = {4'b0000, acc_r} * 12'd10 + {8'b0, digit};
  assign is_byte  = fire && (in_item.mode == MODE_BYTE);
  assign eol      = (c == CHAR_CR) || (c == CHAR_LF);
  assign room     = pos_r < POS_LAST;
  assign line_end = is_byte && eol && (pos_r != '0);
  assign advance  = is_byte && !eol && room;
  assign too_long = is_byte && !eol && !room;
  assign clr      = (fire && (in_item.mode == MODE_OVERFLOW)) || line_end || too_long;
  assign parse_en = advance && !ended_r && (c != CHAR_NUL);

  // line kind
  always_comb begin
    kind_nxt = kind_r;
    if (clr) begin
      kind_nxt = KIND_COMMON;
    end else if (parse_en) begin
      case (kind_r)
        KIND_COMMON: begin
          if (pos_r < POS_W'(5)) begin
            if (c != time_char(pos_r)) kind_nxt = KIND_UNKNOWN;
          end else if (c == CHAR_I) begin
            kind_nxt = KIND_TIME_PREFIX;
          end else if (c == CHAR_M) begin
            kind_nxt = KIND_TM_PREFIX;
          end else begin
            kind_nxt = KIND_UNKNOWN;
          end
        end
        KIND_TIME_PREFIX: begin
          if (pos_r >= POS_W'(9) || c != time_char(pos_r)) kind_nxt = KIND_UNKNOWN;
          else if (pos_r == POS_W'(8)) kind_nxt = KIND_TIME_BODY;
        end
        KIND_TM_PREFIX: kind_nxt = (c == CHAR_EQ) ? KIND_TM_BODY : KIND_UNKNOWN;
        default: kind_nxt = kind_r;
      endcase
    end
  end

  // fields and counters
  always_comb begin
    pos_nxt   = pos_r;
    ended_nxt = ended_r;
    fv_nxt    = fv_r;
    acc_nxt   = acc_r;
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    suf_nxt   = suf_r;
    if (clr) begin
      pos_nxt   = '0;
      ended_nxt = 1'b0;
      fv_nxt    = 1'b1;
      acc_nxt   = '0;
      hour_nxt  = '0;
      min_nxt   = '0;
      suf_nxt   = '0;
    end else if (advance) begin
      pos_nxt = pos_r + POS_W'(1);
      if (!ended_r && c == CHAR_NUL) ended_nxt = 1'b1;
      if (parse_en && (kind_r == KIND_TIME_BODY || kind_r == KIND_TM_BODY)) begin
        if (suf_r < SUF_MAX) suf_nxt = suf_r + SUF_W'(1);
      end
      if (parse_en && kind_r == KIND_TIME_BODY) begin
        if (suf_r >= SUF_W'(8)) begin
          fv_nxt = 1'b0;
        end else if (suf_r == SUF_W'(2) || suf_r == SUF_W'(5)) begin
          if (c != CHAR_COLON) fv_nxt = 1'b0;
        end else if (!is_digit(c)) begin
          fv_nxt = 1'b0;
        end else if (suf_r == SUF_W'(0) || suf_r == SUF_W'(3) || suf_r == SUF_W'(6)) begin
          acc_nxt = {4'b0000, digit};
        end else if (suf_r == SUF_W'(1)) begin
          if (v > HOUR_MAX) fv_nxt = 1'b0;
          hour_nxt = v[4:0];
        end else if (suf_r == SUF_W'(4)) begin
          if (v > MINSEC_MAX) fv_nxt = 1'b0;
          min_nxt = v[5:0];
        end else begin
          if (v > MINSEC_MAX) fv_nxt = 1'b0;
          acc_nxt = v[7:0];
        end
      end
      if (parse_en && kind_r == KIND_TM_BODY && fv_r) begin
        if (!is_digit(c) || v > BYTE_MAX) fv_nxt = 1'b0;
        else acc_nxt = v[7:0];
      end
    end
  end

  // result of this request
  always_comb begin
    res_valid = 1'b0;
    res_data  = '0;
    if (fire && in_item.mode == MODE_OVERFLOW) begin
      res_valid       = 1'b1;
      res_data.status = ST_OVERFLOW;
    end else if (fire && in_item.mode == MODE_FRAMING) begin
      res_valid       = 1'b1;
      res_data.status = ST_FRAMING;
    end else if (too_long) begin
      res_valid       = 1'b1;
      res_data.status = ST_TOO_LONG;
    end else if (line_end) begin
      res_valid = 1'b1;
      case (kind_r)
        KIND_TIME_BODY: begin
          if (fv_r && suf_r == SUF_W'(8)) begin
            res_data.status = ST_CLOCK_SET;
            res_data.hour   = hour_r;
            res_data.minute = min_r;
            res_data.second = acc_r[5:0];
          end else begin
            res_data.status = ST_TIME_FMT;
          end
        end
        KIND_TM_BODY: begin
          if (!fv_r || suf_r == '0) begin
            res_data.status = ST_INTERVAL_FMT;
          end else if (acc_r < cfg.interval_min || acc_r > cfg.interval_max) begin
            res_data.status = ST_RANGE;
          end else begin
            res_data.status   = ST_SET_INTERVAL;
            res_data.interval = acc_r;
          end
        end
        default: res_data.status = ST_UNKNOWN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= KIND_COMMON;
      pos_r   <= '0;
      ended_r <= 1'b0;
      fv_r    <= 1'b1;
      acc_r   <= '0;
      hour_r  <= '0;
      min_r   <= '0;
      suf_r   <= '0;
    end else begin
      kind_r  <= kind_nxt;
      pos_r   <= pos_nxt;
      ended_r <= ended_nxt;
      fv_r    <= fv_nxt;
      acc_r   <= acc_nxt;
      hour_r  <= hour_nxt;
      min_r   <= min_nxt;
      suf_r   <= suf_nxt;
    end
  end

endmodule

FILE: design/ucp_out_buf.sv
// ----------------------------------------------------------------------------
// ucp_out_buf
// Output register with a skid entry behind it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucp_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ucp_pkg::ucp_out_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output ucp_pkg::ucp_out_t out_data
);
  import ucp_pkg::*;

  logic     out_valid_r, out_valid_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  ucp_out_t out_data_r, out_data_nxt;
  ucp_out_t skid_data_r, skid_data_nxt;
  logic     out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = push;
        skid_data_nxt  = push_data;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: design/uart_command_line_parser_top.sv
// ----------------------------------------------------------------------------
// uart_command_line_parser_top
// Parses received UART bytes into set-time and set-interval commands.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------
//   in_      | in_valid / in_stall    | ucp_in_t  (mode, rx_byte)
//   out_     | out_valid / out_stall  | ucp_out_t (status, hour, minute,
//            |                        |            second, interval)
//   cfg      | psel/penable/pwrite    | paddr, pwdata, prdata (interval_min/max)
//
// one request per cycle while in_stall is low; a status reaches the output
// register the cycle after its request, or waits in the skid entry behind a
// stalled status; the line state updates in a single registered step per byte
// synchronous active-low reset clears the line state and both output slots
// in_stall rises only when the output register and its skid entry are both full
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_command_line_parser_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ucp_pkg::ucp_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ucp_pkg::ucp_out_t             out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ucp_pkg::ADDR_W-1:0]    paddr,
  input  logic [ucp_pkg::DATA_W-1:0]    pwdata,
  output logic [ucp_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import ucp_pkg::*;

  ucp_cfg_t cfg_r, cfg_nxt;
  logic     cfg_wr;
  logic     fire;
  logic     full;
  logic     res_valid;
  ucp_out_t res_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (paddr[2])
        REG_INTERVAL_MIN: cfg_nxt.interval_min = pwdata[7:0];
        REG_INTERVAL_MAX: cfg_nxt.interval_max = pwdata[7:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.interval_min <= INTERVAL_MIN_RST;
      cfg_r.interval_max <= INTERVAL_MAX_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_INTERVAL_MIN: prdata = {{(DATA_W-8){1'b0}}, cfg_r.interval_min};
      REG_INTERVAL_MAX: prdata = {{(DATA_W-8){1'b0}}, cfg_r.interval_max};
      default:          prdata = '0;
    endcase
  end

  assign in_stall = full;
  assign fire     = in_valid && !full;

  ucp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .in_item   (in_data),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  ucp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res_data),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: design/ucp_checker.sv
// ----------------------------------------------------------------------------
// ucp_checker
// Port-level checks of the command line parser, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input ucp_pkg::ucp_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input ucp_pkg::ucp_out_t out_data
);
  import ucp_pkg::*;

  // held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // reset empties the output side
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output not empty after reset");

  // input stall only with a result waiting
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("stall without pending result");

  // overflow event into an empty output shows up next cycle
  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid && in_data.mode == MODE_OVERFLOW
    |=> out_valid && out_data.status == ST_OVERFLOW)
    else $error("overflow status missing");

  // set time carries a legal time
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_CLOCK_SET
    |-> out_data.hour <= 5'd23 && out_data.minute <= 6'd59 && out_data.second <= 6'd59)
    else $error("set time out of range");

endmodule

bind uart_command_line_parser_top ucp_checker u_ucp_checker (.*);

FILE: sim/tb_uart_command_line_parser_top.sv
// ----------------------------------------------------------------------------
// tb_uart_command_line_parser_top
// Self-checking bench for the command line parser. A behavioral line parser
// predicts the status of every request that yields one, and each status on
// the out_ channel is compared field by field with the oldest prediction.
// Directed lines come first. Random lines follow under several interval
// limit settings, with random idle bursts on both channels, and a final
// stretch runs without any idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_uart_command_line_parser_top;
  import ucp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 20;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [0:8][7:0] TIME_PREFIX_WORD = "SET_TIME=";

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ucp_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ucp_out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  uart_command_line_parser_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #2 clk = ~clk;

  // parser prediction state
  int          pos_cnt;
  line_kind_t  kind_q;
  logic        text_done;
  logic        fields_ok;
  logic [7:0]  num_acc;
  logic [4:0]  hour_acc;
  logic [5:0]  min_acc;
  logic [4:0]  body_len;
  logic [7:0]  iv_lo;
  logic [7:0]  iv_hi;

  ucp_out_t    status_q[$];
  logic [7:0]  line_bytes[$];
  ucp_out_t    want;
  int          err_cnt = 0;
  int          sent_cnt = 0;
  int          checked_cnt = 0;
  int          cycle_cnt = 0;
  int          hold_left = 0;
  int          status_seen[9];
  bit          quiet = 1'b0;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic void reset_line();
    pos_cnt   = 0;
    kind_q    = KIND_COMMON;
    text_done = 1'b0;
    fields_ok = 1'b1;
    num_acc   = '0;
    hour_acc  = '0;
    min_acc   = '0;
    body_len  = '0;
  endfunction

  function automatic void time_body_char(input logic [7:0] c);
    logic [11:0] v;
    v = 12'(num_acc) * 12'd10 + 12'(c - "0");
    if (body_len >= 5'd8) begin
      fields_ok = 1'b0;
    end else if (body_len == 5'd2 || body_len == 5'd5) begin
      if (c != CHAR_COLON) fields_ok = 1'b0;
    end else if (!is_dec(c)) begin
      fields_ok = 1'b0;
    end else if (body_len == 5'd0 || body_len == 5'd3 || body_len == 5'd6) begin
      num_acc = c - "0";
    end else if (body_len == 5'd1) begin
      if (v > HOUR_MAX) fields_ok = 1'b0;
      hour_acc = v[4:0];
    end else if (body_len == 5'd4) begin
      if (v > MINSEC_MAX) fields_ok = 1'b0;
      min_acc = v[5:0];
    end else begin
      if (v > MINSEC_MAX) fields_ok = 1'b0;
      num_acc = v[7:0];
    end
    if (body_len != SUF_MAX) body_len++;
  endfunction

  function automatic void interval_body_char(input logic [7:0] c);
    logic [11:0] v;
    v = 12'(num_acc) * 12'd10 + 12'(c - "0");
    if (fields_ok) begin
      if (!is_dec(c)) fields_ok = 1'b0;
      else if (v > BYTE_MAX) fields_ok = 1'b0;
      else num_acc = v[7:0];
    end
    if (body_len != SUF_MAX) body_len++;
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    case (kind_q)
      KIND_COMMON: begin
        if (pos_cnt < 5) begin
          if (c != TIME_PREFIX_WORD[pos_cnt]) kind_q = KIND_UNKNOWN;
        end else if (c == CHAR_I) begin
          kind_q = KIND_TIME_PREFIX;
        end else if (c == CHAR_M) begin
          kind_q = KIND_TM_PREFIX;
        end else begin
          kind_q = KIND_UNKNOWN;
        end
      end
      KIND_TIME_PREFIX: begin
        if (pos_cnt >= 9) kind_q = KIND_UNKNOWN;
        else if (c != TIME_PREFIX_WORD[pos_cnt]) kind_q = KIND_UNKNOWN;
        else if (pos_cnt == 8) kind_q = KIND_TIME_BODY;
      end
      KIND_TM_PREFIX: kind_q = (c == CHAR_EQ) ? KIND_TM_BODY : KIND_UNKNOWN;
      KIND_TIME_BODY: time_body_char(c);
      KIND_TM_BODY: interval_body_char(c);
      default: ;
    endcase
  endfunction

  function automatic ucp_out_t close_line();
    ucp_out_t r;
    r = '0;
    if (kind_q == KIND_TIME_BODY) begin
      if (fields_ok && body_len == 5'd8) begin
        r.status = ST_CLOCK_SET;
        r.hour   = hour_acc;
        r.minute = min_acc;
        r.second = num_acc[5:0];
      end else begin
        r.status = ST_TIME_FMT;
      end
    end else if (kind_q == KIND_TM_BODY) begin
      if (!fields_ok || body_len == 5'd0) begin
        r.status = ST_INTERVAL_FMT;
      end else if (num_acc < iv_lo || num_acc > iv_hi) begin
        r.status = ST_RANGE;
      end else begin
        r.status   = ST_SET_INTERVAL;
        r.interval = num_acc;
      end
    end else begin
      r.status = ST_UNKNOWN;
    end
    return r;
  endfunction

  function automatic void predict_status(input ucp_in_t req);
    ucp_out_t r;
    r = '0;
    case (req.mode)
      MODE_OVERFLOW: begin
        reset_line();
        r.status = ST_OVERFLOW;
        status_q.push_back(r);
      end
      MODE_FRAMING: begin
        r.status = ST_FRAMING;
        status_q.push_back(r);
      end
      MODE_BYTE: begin
        if (req.rx_byte == CHAR_CR || req.rx_byte == CHAR_LF) begin
          if (pos_cnt != 0) begin
            status_q.push_back(close_line());
            reset_line();
          end
        end else if (pos_cnt < LINE_CAPACITY - 1) begin
          if (!text_done) begin
            if (req.rx_byte == CHAR_NUL) text_done = 1'b1;
            else parse_char(req.rx_byte);
          end
          pos_cnt++;
        end else begin
          reset_line();
          r.status = ST_TOO_LONG;
          status_q.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(input logic [1:0] mode, input logic [7:0] ch);
    ucp_in_t req;
    req.mode    = mode;
    req.rx_byte = ch;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_status(req);
    if (mode != MODE_UNUSED) sent_cnt++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_request(MODE_BYTE, s[i]);
  endtask

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endfunction

  task automatic write_reg(input logic reg_idx, input logic [7:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (reg_idx == REG_INTERVAL_MIN) iv_lo = value;
    else iv_hi = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_random_line();
    string txt;
    int pick;
    int cut;
    line_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      if ($urandom_range(0, 3) != 0)
        txt = $sformatf("SET_TIME=%02d:%02d:%02d", $urandom_range(0, 23),
                        $urandom_range(0, 59), $urandom_range(0, 59));
      else
        txt = $sformatf("SET_TIME=%02d:%02d:%02d", $urandom_range(0, 99),
                        $urandom_range(0, 99), $urandom_range(0, 99));
      case ($urandom_range(0, 9))
        0: txt = {txt, "7"};
        1: txt = txt.substr(0, txt.len() - 2);
        default: ;
      endcase
      add_text(txt);
    end else if (pick < 65) begin
      case ($urandom_range(0, 3))
        0: txt = $sformatf("SET_TM=%0d", $urandom_range(0, 300));
        1: txt = $sformatf("SET_TM=%03d", $urandom_range(0, 999));
        2: txt = $sformatf("SET_TM=%0d", $urandom_range(0, 70));
        default: txt = $sformatf("SET_TM=%0d", $urandom_range(0, 99999));
      endcase
      add_text(txt);
    end else if (pick < 75) begin
      txt = $urandom_range(0, 1) ? "SET_TIME=" : "SET_TM=";
      cut = $urandom_range(0, txt.len());
      add_text(txt.substr(0, cut - 1));
      repeat ($urandom_range(0, 3)) line_bytes.push_back(8'($urandom_range(32, 126)));
    end else if (pick < 90) begin
      repeat ($urandom_range(0, 40)) line_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(28, 40)) line_bytes.push_back(8'($urandom_range(32, 126)));
    end
    if ($urandom_range(0, 6) == 0 && line_bytes.size() > 0) begin
      cut = $urandom_range(0, line_bytes.size() - 1);
      if ($urandom_range(0, 1)) line_bytes[cut] = 8'($urandom_range(0, 255));
      else line_bytes.insert(cut, CHAR_NUL);
    end
    foreach (line_bytes[i]) begin
      if ($urandom_range(0, 79) == 0)
        send_request(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
      send_request(MODE_BYTE, line_bytes[i]);
    end
    case ($urandom_range(0, 19))
      0: ;
      1, 2, 3, 4, 5, 6, 7, 8, 9: send_request(MODE_BYTE, CHAR_CR);
      default: send_request(MODE_BYTE, CHAR_LF);
    endcase
  endtask

  task automatic run_lines(input int n);
    int target;
    target = sent_cnt + n;
    while (sent_cnt < target) send_random_line();
  endtask

  task automatic test_directed();
    send_text("SET_TIME=23:59:59");
    send_request(MODE_BYTE, CHAR_CR);
    send_request(MODE_BYTE, CHAR_LF);
    send_request(MODE_OVERFLOW, 8'hFF);
    send_request(MODE_FRAMING, 8'h00);
    send_request(MODE_UNUSED, 8'hA5);
    send_text("SE");
    send_request(MODE_BYTE, CHAR_NUL);
    send_text("M");
    send_request(MODE_BYTE, CHAR_LF);
  endtask

  task automatic test_interval_limits();
    logic [7:0] lo;
    logic [7:0] hi;
    for (int k = 0; k < 5; k++) begin
      case (k)
        0: begin lo = 8'd0;   hi = 8'd255; end
        1: begin lo = 8'd255; hi = 8'd255; end
        2: begin lo = 8'd0;   hi = 8'd0;   end
        3: begin lo = 8'd255; hi = 8'd0;   end
        default: begin
          lo = 8'($urandom_range(0, 120));
          hi = 8'($urandom_range(lo, 255));
        end
      endcase
      wait_idle();
      write_reg(REG_INTERVAL_MIN, lo);
      write_reg(REG_INTERVAL_MAX, hi);
      run_lines(220);
    end
  endtask

  task automatic test_steady_stream();
    wait_idle();
    write_reg(REG_INTERVAL_MIN, INTERVAL_MIN_RST);
    write_reg(REG_INTERVAL_MAX, INTERVAL_MAX_RST);
    quiet = 1'b1;
    run_lines(250);
  endtask

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned got_v);
    if (exp_v != got_v) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
    end
  endfunction

  // receiver stall bursts
  always @(negedge clk) begin
    if (quiet || !rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 11) == 0) begin
      hold_left = $urandom_range(1, 16) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (status_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("%0t: unexpected status, expected none, got %0d", $time, out_data.status);
      end else begin
        want = status_q.pop_front();
        checked_cnt++;
        if (out_data.status < 4'd9) status_seen[out_data.status]++;
        check_field("status", want.status, out_data.status);
        check_field("hour", want.hour, out_data.hour);
        check_field("minute", want.minute, out_data.minute);
        check_field("second", want.second, out_data.second);
        check_field("interval", want.interval, out_data.interval);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d statuses outstanding", cycle_cnt,
               status_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    foreach (status_seen[i]) status_seen[i] = 0;
    iv_lo = INTERVAL_MIN_RST;
    iv_hi = INTERVAL_MAX_RST;
    reset_line();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_interval_limits();
    test_steady_stream();

    wait_idle();
    repeat (8) @(posedge clk);
    if (status_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d statuses never arrived", $time, status_q.size());
    end

    $display("%0d requests, %0d statuses checked over six interval limit settings",
             sent_cnt, checked_cnt);
    $display("time %0d, interval %0d, format %0d/%0d, range %0d, unknown %0d,",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    $display("events %0d/%0d, long %0d", status_seen[6], status_seen[7], status_seen[8]);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
